[src/sra_pkg.sv]
// shared types, constants and helpers for the signed radix-to-ascii converter
// no dependencies
package sra_pkg;

    localparam int VALUE_W     = 32;
    localparam int CHAR_W      = 8;
    localparam int CNT_W       = 5;
    localparam int ALPHA_W     = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int DIG_W       = 4;
    localparam int STACK_DEPTH = 32;
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int STK_CNT_W   = SP_W + 1;
    localparam int CHARS_PER_W = ALPHA_W / CHAR_W;

    localparam logic [CNT_W-1:0] MAX_BASE = CNT_W'(16);
    localparam logic [CNT_W-1:0] MIN_BASE = CNT_W'(2);

    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_HIGH = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_SIGN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic               start;
        logic [VALUE_W-1:0] dividend;
        logic [CNT_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] quotient;
        logic [DIG_W-1:0]   remainder;
    } t_div_rsp;

    function automatic logic [CHAR_W-1:0] alpha_char(
        input logic [ALPHA_W-1:0] lo,
        input logic [ALPHA_W-1:0] hi,
        input logic [DIG_W-1:0]   idx
    );
        logic [ALPHA_W-1:0] word;
        word = idx[DIG_W-1] ? hi : lo;
        return word[idx[DIG_W-2:0]*CHAR_W +: CHAR_W];
    endfunction

endpackage

[src/sra_in_if.sv]
// input channel: valid/ready handshake carrying the signed value
// depends on sra_pkg
interface sra_in_if;
    import sra_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    modport source (output valid, value, input ready);
    modport sink   (input valid, value, output ready);
endinterface

[src/sra_out_if.sv]
// output channel: valid/ready handshake carrying one character per transaction
// depends on sra_pkg
interface sra_out_if;
    import sra_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              final_char;
    modport source (output valid, out_char, final_char, input ready);
    modport sink   (input valid, out_char, final_char, output ready);
endinterface

[src/signed_radix_to_ascii.sv]
// signed radix-to-ascii converter: one value in, sign and digits out
// flow: checks each of the digit_count alphabet positions, then divides once per digit in the
// shared divider, then sends the sign if negative and one character per transaction
// one value at a time: a new value is accepted only when the sequencer is back in idle
// reset: synchronous active-low, clears the sequencer and configuration to 0
// depends on sra_pkg, sra_in_if, sra_out_if, sra_div, sra_alpha_chk
module signed_radix_to_ascii (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sra_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sra_pkg::ALPHA_W-1:0]   i_cfg_data,
    sra_in_if.sink                        i_in,
    sra_out_if.source                     o_out
);
    import sra_pkg::*;

    logic [CNT_W-1:0]   r_digit_count;
    logic [ALPHA_W-1:0] r_alpha_low;
    logic [ALPHA_W-1:0] r_alpha_high;

    t_state             r_state, n_state;
    logic [DIG_W-1:0]   r_idx, n_idx;
    logic [STK_CNT_W-1:0] r_cnt, n_cnt;
    logic [VALUE_W-1:0] r_mag, n_mag;
    logic               r_neg, n_neg;
    logic               r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]  r_out_char, n_out_char;
    logic               r_out_final, n_out_final;
    logic [DIG_W-1:0]   r_stack [STACK_DEPTH];

    t_div_req             div_req;
    t_div_rsp             div_rsp;
    logic                 chk_bad;
    logic                 push;
    logic                 out_free;
    logic [CNT_W-1:0]     last_idx;
    logic [STK_CNT_W-1:0] cnt_m1;
    logic [VALUE_W-1:0]   raw;

    sra_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    sra_alpha_chk u_chk (
        .i_digit_count (r_digit_count),
        .i_idx         (r_idx),
        .i_alpha_low   (r_alpha_low),
        .i_alpha_high  (r_alpha_high),
        .o_bad         (chk_bad)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count <= '0;
            r_alpha_low   <= '0;
            r_alpha_high  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DIGIT_COUNT:   r_digit_count <= i_cfg_data[CNT_W-1:0];
                CFG_ALPHABET_LOW:  r_alpha_low   <= i_cfg_data;
                CFG_ALPHABET_HIGH: r_alpha_high  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state          = r_state;
        n_idx            = r_idx;
        n_cnt            = r_cnt;
        n_mag            = r_mag;
        n_neg            = r_neg;
        out_free         = !r_out_valid || o_out.ready;
        n_out_valid      = r_out_valid && !o_out.ready;
        n_out_char       = r_out_char;
        n_out_final      = r_out_final;
        div_req.start    = 1'b0;
        div_req.dividend = div_rsp.quotient;
        div_req.divisor  = r_digit_count;
        push             = 1'b0;
        last_idx         = r_digit_count - CNT_W'(1);
        cnt_m1           = r_cnt - STK_CNT_W'(1);
        raw              = i_in.value;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_neg   = raw[VALUE_W-1];
                    n_mag   = raw[VALUE_W-1] ? ('0 - raw) : raw;
                    n_idx   = '0;
                    n_cnt   = '0;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (chk_bad) begin
                    n_state = S_IDLE;
                end else if ({1'b0, r_idx} == last_idx) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = r_mag;
                    n_state          = S_DIV;
                end else begin
                    n_idx = r_idx + DIG_W'(1);
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    push  = 1'b1;
                    n_cnt = r_cnt + STK_CNT_W'(1);
                    if (div_rsp.quotient == '0 ||
                        r_cnt == STK_CNT_W'(STACK_DEPTH - 1)) begin
                        n_state = r_neg ? S_SIGN : S_EMIT;
                    end else begin
                        div_req.start = 1'b1;
                    end
                end
            end
            S_SIGN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CHAR_MINUS;
                    n_out_final = 1'b0;
                    n_state     = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = alpha_char(r_alpha_low, r_alpha_high,
                                             r_stack[cnt_m1[SP_W-1:0]]);
                    n_out_final = (r_cnt == STK_CNT_W'(1));
                    n_cnt       = cnt_m1;
                    if (r_cnt == STK_CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag       <= n_mag;
        r_neg       <= n_neg;
        r_out_char  <= n_out_char;
        r_out_final <= n_out_final;
        if (push) begin
            r_stack[r_cnt[SP_W-1:0]] <= div_rsp.remainder;
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.out_char   = r_out_char;
    assign o_out.final_char = r_out_final;

`ifndef NO_ASSERTIONS
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_CHECK))
        else $error("accepted transaction did not start the alphabet check");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    a_emit_has_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT || r_state == S_SIGN) |-> (r_cnt != '0))
        else $error("emission with an empty digit stack");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= STK_CNT_W'(STACK_DEPTH))
        else $error("digit stack overflow");
`endif

endmodule

[src/sra_div.sv]
// shared restoring divider, one quotient bit per cycle
// depends on sra_pkg
module sra_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sra_pkg::t_div_req i_req,
    output sra_pkg::t_div_rsp o_rsp
);
    import sra_pkg::*;

    logic [VALUE_W-1:0] r_quo, n_quo;
    logic [DIG_W-1:0]   r_rem, n_rem;
    logic [CNT_W-1:0]   r_divisor;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   trial;
    logic               ge;
    logic [CNT_W-1:0]   diff;

    always_comb begin
        trial = {r_rem, r_quo[VALUE_W-1]};
        ge    = trial >= r_divisor;
        diff  = trial - r_divisor;
        n_rem = ge ? diff[DIG_W-1:0] : trial[DIG_W-1:0];
        n_quo = {r_quo[VALUE_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(VALUE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo     <= i_req.dividend;
            r_rem     <= '0;
            r_divisor <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

[src/sra_alpha_chk.sv]
// alphabet checker for one character position: range, sign characters,
// the byte range 8'h21 to 8'h7F and duplicates against lower positions; depends on sra_pkg
module sra_alpha_chk (
    input  logic [sra_pkg::CNT_W-1:0]   i_digit_count,
    input  logic [sra_pkg::DIG_W-1:0]   i_idx,
    input  logic [sra_pkg::ALPHA_W-1:0] i_alpha_low,
    input  logic [sra_pkg::ALPHA_W-1:0] i_alpha_high,
    output logic                        o_bad
);
    import sra_pkg::*;

    logic [CHAR_W-1:0] c;

    always_comb begin
        c     = alpha_char(i_alpha_low, i_alpha_high, i_idx);
        o_bad = (i_digit_count < MIN_BASE) || (i_digit_count > MAX_BASE) ||
                (c == CHAR_PLUS) || (c == CHAR_MINUS) || (c <= CHAR_SPACE) ||
                c[CHAR_W-1];
        for (int j = 0; j < (1 << DIG_W); j++) begin
            if ((DIG_W'(j) < i_idx) &&
                (alpha_char(i_alpha_low, i_alpha_high, DIG_W'(j)) == c)) begin
                o_bad = 1'b1;
            end
        end
    end

endmodule

[test/signed_radix_to_ascii_tb.sv]
// testbench for signed_radix_to_ascii: directed and random values over many alphabets
// predicts every character from the programmed alphabet, checks each output transaction
// depends on sra_pkg, sra_in_if, sra_out_if and the signed_radix_to_ascii rtl
module signed_radix_to_ascii_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sra_pkg::*;

    localparam int SETTLE_CYCLES  = 1200;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 380;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_char_exp;

    typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_SPARSE} t_rx_mode;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ALPHA_W-1:0]   cfg_data;

    sra_in_if  in_ch ();
    sra_out_if out_ch ();

    signed_radix_to_ascii dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    logic [CNT_W-1:0]   cfg_count;
    logic [ALPHA_W-1:0] cfg_alpha_lo;
    logic [ALPHA_W-1:0] cfg_alpha_hi;

    logic [VALUE_W-1:0] pending_values [$];
    t_char_exp          expected_chars [$];
    int unsigned        values_queued;
    int unsigned        values_accepted;
    int unsigned        chars_seen;
    int unsigned        mismatch_count;
    int unsigned        idle_cycles;
    int                 burst_left;
    int                 gap_left;
    t_rx_mode           rx_mode;
    int                 rx_span;
    t_char_exp          want;
    t_char_exp          got;
    bit                 progress;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [CHAR_W-1:0] char_at(input int idx);
        logic [2*ALPHA_W-1:0] a;
        a = {cfg_alpha_hi, cfg_alpha_lo};
        return a[CHAR_W*idx +: CHAR_W];
    endfunction

    function automatic void predict_chars(input logic [VALUE_W-1:0] raw);
        logic [CHAR_W-1:0]  digits [STACK_DEPTH];
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] base;
        logic [CHAR_W-1:0]  c;
        int                 nd;
        if (cfg_count < MIN_BASE || cfg_count > MAX_BASE) return;
        for (int i = 0; i < int'(cfg_count); i++) begin
            c = char_at(i);
            if (c == CHAR_PLUS || c == CHAR_MINUS || c <= CHAR_SPACE || c[CHAR_W-1]) return;
            for (int j = 0; j < i; j++)
                if (char_at(j) == c) return;
        end
        base = VALUE_W'(cfg_count);
        mag  = raw[VALUE_W-1] ? -raw : raw;
        nd   = 0;
        do begin
            digits[nd] = char_at(int'(mag % base));
            nd++;
            mag = mag / base;
        end while (mag != 0 && nd < STACK_DEPTH);
        if (raw[VALUE_W-1])
            expected_chars.push_back(t_char_exp'{CHAR_MINUS, 1'b0});
        for (int k = nd - 1; k >= 0; k--)
            expected_chars.push_back(t_char_exp'{digits[k], k == 0});
    endfunction

    function automatic logic [2*ALPHA_W-1:0] make_alphabet(input string s);
        logic [2*ALPHA_W-1:0] a;
        for (int i = 0; i < 2 * CHARS_PER_W; i++)
            a[CHAR_W*i +: CHAR_W] = (i < s.len()) ? s[i] : CHAR_W'($urandom_range(0, 255));
        return a;
    endfunction

    task automatic flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s", $time, msg);
    endtask

    task automatic program_alphabet(input logic [CNT_W-1:0] count,
                                    input logic [2*ALPHA_W-1:0] alpha);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DIGIT_COUNT;
        cfg_data  <= {32'($urandom), 27'($urandom), count};
        @(posedge i_clk);
        cfg_index <= CFG_ALPHABET_LOW;
        cfg_data  <= alpha[ALPHA_W-1:0];
        @(posedge i_clk);
        cfg_index <= CFG_ALPHABET_HIGH;
        cfg_data  <= alpha[2*ALPHA_W-1:ALPHA_W];
        @(posedge i_clk);
        cfg_we       <= 1'b0;
        cfg_count    = count;
        cfg_alpha_lo = alpha[ALPHA_W-1:0];
        cfg_alpha_hi = alpha[2*ALPHA_W-1:ALPHA_W];
    endtask

    task automatic queue_value(input logic [VALUE_W-1:0] v);
        pending_values.push_back(v);
        values_queued++;
    endtask

    task automatic drain();
        while (values_accepted != values_queued || expected_chars.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // sender: bursts of transactions separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (gap_left > 0) begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end else if (pending_values.size() > 0) begin
                in_ch.valid <= 1'b1;
                in_ch.value <= pending_values.pop_front();
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: ready pattern switching between open, light and heavy stalls
    always @(posedge i_clk) begin
        if (rx_span == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 2));
            rx_span = $urandom_range(40, 300);
        end
        rx_span--;
        case (rx_mode)
            RX_ALWAYS: out_ch.ready <= 1'b1;
            RX_MOSTLY: out_ch.ready <= ($urandom_range(0, 3) != 0);
            default:   out_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            progress = 1'b0;
            if (in_ch.valid && in_ch.ready) begin
                predict_chars(in_ch.value);
                values_accepted++;
                progress = 1'b1;
            end
            if (out_ch.valid && out_ch.ready) begin
                got = t_char_exp'{out_ch.out_char, out_ch.final_char};
                if (expected_chars.size() == 0) begin
                    flag_error($sformatf("character %0d unexpected: %h final %0b",
                                         chars_seen, got.ch, got.last));
                end else begin
                    want = expected_chars.pop_front();
                    if (got.ch !== want.ch || got.last !== want.last)
                        flag_error($sformatf(
                            "character %0d: expected %h final %0b, got %h final %0b",
                            chars_seen, want.ch, want.last, got.ch, got.last));
                end
                chars_seen++;
                progress = 1'b1;
            end
            idle_cycles = progress ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("signed_radix_to_ascii regression: fail");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [2*ALPHA_W-1:0] alpha;
        logic [CNT_W-1:0]     count;
        logic [VALUE_W-1:0]   v;
        logic [255:0]         used;
        logic [CHAR_W-1:0]    c;
        int                   p;
        int                   q;
        int                   batch;
        int                   valid_items;
        longint               pw;
        bit                   broken;

        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_DIGIT_COUNT;
        cfg_data      = '0;
        cfg_count     = '0;
        cfg_alpha_lo  = '0;
        cfg_alpha_hi  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (20) @(posedge i_clk);

        // registers still at reset: empty alphabet
        queue_value(32'h0);
        queue_value(32'hFFFF_FFFF);
        drain();

        program_alphabet(5'd10, make_alphabet("0123456789"));
        queue_value(32'h0);
        queue_value(32'h1);
        queue_value(32'hFFFF_FFFF);
        queue_value(32'h7FFF_FFFF);
        queue_value(32'h8000_0000);
        queue_value(32'd10);
        queue_value(-32'd1234567890);
        drain();

        program_alphabet(5'd2, make_alphabet("01"));
        queue_value(32'h8000_0000);
        queue_value(32'hFFFF_FFFF);
        queue_value(32'h7FFF_FFFF);
        queue_value(32'd5);
        drain();

        program_alphabet(5'd16, make_alphabet("0123456789ABCDEF"));
        queue_value(32'hDEAD_BEEF);
        queue_value(32'd255);
        queue_value(-32'd256);
        drain();

        // edge bytes that are still legal digits
        alpha = make_alphabet("!~");
        alpha[2*CHAR_W +: CHAR_W] = 8'h7F;
        program_alphabet(5'd3, alpha);
        queue_value(32'h8000_0000);
        drain();

        for (int k = 0; k < 9; k++) begin
            alpha = make_alphabet("0123456789ABCDEF");
            count = 5'd10;
            case (k)
                0: count = 5'd1;
                1: count = 5'd17;
                2: count = 5'd31;
                3: alpha[3*CHAR_W +: CHAR_W] = CHAR_PLUS;
                4: alpha[9*CHAR_W +: CHAR_W] = CHAR_MINUS;
                5: alpha[0 +: CHAR_W] = CHAR_SPACE;
                6: alpha[5*CHAR_W +: CHAR_W] = 8'h80;
                7: alpha[2*CHAR_W +: CHAR_W] = 8'hFF;
                default: begin
                    count = 5'd16;
                    alpha[15*CHAR_W +: CHAR_W] = alpha[0 +: CHAR_W];
                end
            endcase
            program_alphabet(count, alpha);
            queue_value($urandom);
            drain();
        end

        valid_items = 0;
        while (valid_items < RANDOM_ITEMS) begin
            count = CNT_W'($urandom_range(MIN_BASE, MAX_BASE));
            used  = '0;
            for (int i = 0; i < 2 * CHARS_PER_W; i++) begin
                if (i < int'(count)) begin
                    do c = CHAR_W'($urandom_range(33, 127));
                    while (c == CHAR_PLUS || c == CHAR_MINUS || used[c]);
                    used[c] = 1'b1;
                    alpha[CHAR_W*i +: CHAR_W] = c;
                end else begin
                    alpha[CHAR_W*i +: CHAR_W] = CHAR_W'($urandom_range(0, 255));
                end
            end
            broken = ($urandom_range(0, 7) == 0);
            if (broken) begin
                p = $urandom_range(0, count - 1);
                case ($urandom_range(0, 5))
                    0: count = CNT_W'($urandom_range(0, 1));
                    1: count = CNT_W'($urandom_range(17, 31));
                    2: alpha[CHAR_W*p +: CHAR_W] =
                           $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
                    3: alpha[CHAR_W*p +: CHAR_W] = CHAR_W'($urandom_range(0, CHAR_SPACE));
                    4: alpha[CHAR_W*p +: CHAR_W] = CHAR_W'($urandom_range(128, 255));
                    default: begin
                        do q = $urandom_range(0, count - 1); while (q == p);
                        alpha[CHAR_W*p +: CHAR_W] = alpha[CHAR_W*q +: CHAR_W];
                    end
                endcase
            end
            program_alphabet(count, alpha);
            batch = broken ? $urandom_range(1, 3) : $urandom_range(8, 30);
            repeat (batch) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: v = $urandom;
                    4, 5: begin
                        v = $urandom_range(0, 2000);
                        if ($urandom_range(0, 1)) v = -v;
                    end
                    6: begin
                        v = $urandom >> $urandom_range(0, 31);
                        if ($urandom_range(0, 1)) v = -v;
                    end
                    7, 8: begin
                        pw = 1;
                        if (count >= MIN_BASE)
                            repeat ($urandom_range(0, 31))
                                if (pw * count <= 64'h8000_0000) pw = pw * count;
                        v = VALUE_W'(pw + $urandom_range(0, 2) - 1);
                        if ($urandom_range(0, 1)) v = -v;
                    end
                    default: begin
                        case ($urandom_range(0, 5))
                            0: v = 32'h0;
                            1: v = 32'h1;
                            2: v = 32'hFFFF_FFFF;
                            3: v = 32'h7FFF_FFFF;
                            4: v = 32'h8000_0000;
                            default: v = 32'h8000_0001;
                        endcase
                    end
                endcase
                queue_value(v);
            end
            if (!broken) valid_items += batch;
            drain();
        end

        if (mismatch_count == 0 && expected_chars.size() == 0)
            $display("signed_radix_to_ascii regression: pass");
        else
            $display("signed_radix_to_ascii regression: fail");
        $finish;
    end

endmodule

[files.f]
src/sra_pkg.sv
src/sra_in_if.sv
src/sra_out_if.sv
src/sra_div.sv
src/sra_alpha_chk.sv
src/signed_radix_to_ascii.sv
test/signed_radix_to_ascii_tb.sv
